// ===== design/arp_pkg.sv =====
// shared types, codes and helpers of the note arpeggiator
`timescale 1ns / 1ps

package arp_pkg;

   // pitch range and pattern building constants
   localparam int NUM_PITCH  = 128;
   localparam int PITCH_W    = 7;
   localparam int VEL_W      = 16;
   localparam int ORDER_W    = 16;
   localparam int TIMER_W    = 20;
   localparam int RNG_W      = 32;
   localparam int ENTRY_W    = PITCH_W + VEL_W;
   localparam int KEY_W      = ORDER_W + PITCH_W;
   localparam int OCT_STEP   = 12;
   localparam int MAX_PITCH  = 127;

   // input commands
   localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
   localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
   localparam logic [1:0] CMD_TICK     = 2'd2;

   // pattern orders
   localparam logic [2:0] DIR_UP        = 3'd0;
   localparam logic [2:0] DIR_DOWN      = 3'd1;
   localparam logic [2:0] DIR_UP_DOWN   = 3'd2;
   localparam logic [2:0] DIR_DOWN_UP   = 3'd3;
   localparam logic [2:0] DIR_AS_PLAYED = 3'd4;
   localparam logic [2:0] DIR_RANDOM    = 3'd5;

   // register indexes
   localparam logic [2:0] CSR_DIRECTION   = 3'd0;
   localparam logic [2:0] CSR_OCTAVE_SPAN = 3'd1;
   localparam logic [2:0] CSR_STEP_PERIOD = 3'd2;
   localparam logic [2:0] CSR_GATE_LENGTH = 3'd3;
   localparam logic [2:0] CSR_RNG_SEED    = 3'd4;

   // register reset values
   localparam logic [2:0]         RST_DIRECTION   = DIR_UP;
   localparam logic [2:0]         RST_OCTAVE_SPAN = 3'd1;
   localparam logic [TIMER_W-1:0] RST_STEP_PERIOD = 20'd6000;
   localparam logic [TIMER_W-1:0] RST_GATE_LENGTH = 20'd3000;
   localparam logic [RNG_W-1:0]   RST_RNG_SEED    = 32'd1;

   // result kinds
   localparam logic EVT_NOTE_OFF = 1'b0;
   localparam logic EVT_NOTE_ON  = 1'b1;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_WR,
      ST_SORT_PASS,
      ST_SORT_VEL,
      ST_SORT_WR,
      ST_PAT_RD,
      ST_PAT_WR,
      ST_MIR_RD,
      ST_MIR_WR,
      ST_FINISH,
      ST_TICK,
      ST_TK_REM,
      ST_TK_RD,
      ST_TK_DATA,
      ST_EMIT_OFF,
      ST_EMIT_ON
   } arp_state_type;

   // request to the remainder unit
   typedef struct packed {
      logic             start;
      logic [RNG_W-1:0] dividend;
   } arp_rem_req_type;

   // one xorshift32 step
   function automatic logic [RNG_W-1:0] xorshift32(input logic [RNG_W-1:0] r);
      logic [RNG_W-1:0] v;
      v = r ^ (r << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
   endfunction

endpackage

// ===== design/note_arpeggiator_unit.sv =====
// arpeggiator top level: held note store, pattern builder and step timing
//
//  channel | direction | handshake        | payload
//  req_    | in        | valid / ready    | command, channel, note, velocity
//  rsp_    | out       | valid / ready    | event_kind, out_channel, out_note,
//          |           |                  | out_velocity, last
//  csr_    | in        | write enable     | index, 32-bit write data
//
// a note event rebuilds the pattern: a 128-pitch scan (as played: one pass
// per held note plus one), then a read and a write per held note per octave,
// a read and a write per mirrored step, and a finish step.
// a tick on an empty pattern does nothing; in random mode a tick also waits
// for the remainder unit.
// sync reset clears held notes (valid bits), timers and registers.
// req_ready is high only when idle; a result waiting on rsp_ready stalls the
// sequencer but the last result of an item does not block the next transfer.
`timescale 1ns / 1ps

module note_arpeggiator_unit
   import arp_pkg::*;
#(
   parameter int MAX_PATTERN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_note,
   input  logic [15:0] req_velocity,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_event_kind,
   output logic [3:0]  rsp_out_channel,
   output logic [6:0]  rsp_out_note,
   output logic [15:0] rsp_out_velocity,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int POS_W = $clog2(MAX_PATTERN);

   // configuration
   logic [2:0]         dir_ff, span_ff;
   logic [TIMER_W-1:0] period_ff, gate_len_ff;

   // control state
   arp_state_type        state_ff, state_in;
   logic [NUM_PITCH-1:0] held_ff, held_in;
   logic [7:0]           held_cnt_ff, held_cnt_in;
   logic [ORDER_W-1:0]   order_ff, order_in;
   logic [3:0]           last_chan_ff, last_chan_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 snd_valid_ff, snd_valid_in;
   logic [PITCH_W-1:0]   snd_note_ff, snd_note_in;
   logic [TIMER_W-1:0]   samples_ff, samples_in;
   logic [TIMER_W-1:0]   gate_ff, gate_in;
   logic [RNG_W-1:0]     rnd_ff, rnd_in;
   logic                 is_on_ff, is_on_in;

   // rebuild sequencing
   logic [7:0]         scan_ff, scan_in;
   logic [7:0]         n_ff, n_in;
   logic [7:0]         li_ff, li_in;
   logic [2:0]         oct_j_ff, oct_j_in;
   logic [7:0]         oct_off_ff, oct_off_in;
   logic [LEN_W-1:0]   mir_ff, mir_in;
   logic [PITCH_W-1:0] best_ff, best_in;
   logic [KEY_W-1:0]   best_key_ff, best_key_in;
   logic               found_ff, found_in;
   logic [KEY_W-1:0]   prev_key_ff, prev_key_in;
   logic               first_ff, first_in;
   logic               pd_valid_ff, pd_valid_in;
   logic [PITCH_W-1:0] pd_pitch_ff, pd_pitch_in;

   // tick and result staging
   logic [POS_W-1:0]   idx_ff, idx_in;
   logic [PITCH_W-1:0] off_note_ff, off_note_in;
   logic               off_last_ff, off_last_in;
   logic               then_on_ff, then_on_in;
   logic [PITCH_W-1:0] on_note_ff, on_note_in;
   logic [VEL_W-1:0]   on_vel_ff, on_vel_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [3:0]         rsp_chan_ff, rsp_chan_in;
   logic [PITCH_W-1:0] rsp_note_ff, rsp_note_in;
   logic [VEL_W-1:0]   rsp_vel_ff, rsp_vel_in;
   logic               rsp_last_ff, rsp_last_in;

   // memories
   logic [VEL_W-1:0]   vel_mem [NUM_PITCH];
   logic [ORDER_W-1:0] arr_mem [NUM_PITCH];
   logic [ENTRY_W-1:0] list_mem [NUM_PITCH];
   logic [ENTRY_W-1:0] pat_mem [MAX_PATTERN];
   logic [VEL_W-1:0]   vel_rd_ff;
   logic [ORDER_W-1:0] arr_rd_ff;
   logic [ENTRY_W-1:0] list_rd_ff;
   logic [ENTRY_W-1:0] pat_rd_ff;
   logic [PITCH_W-1:0] vel_addr, arr_addr, list_addr;
   logic [POS_W-1:0]   pat_addr;
   logic               list_we, pat_we;
   logic [PITCH_W-1:0] list_waddr;
   logic [POS_W-1:0]   pat_waddr;
   logic [ENTRY_W-1:0] list_wdata, pat_wdata;

   // remainder unit
   arp_rem_req_type    rem_req;
   logic               rem_done;
   logic [LEN_W-1:0]   rem_value;

   // helpers
   logic               accept, out_free, falling, note_on_evt;
   logic [2:0]         span_eff;
   logic [PITCH_W-1:0] scan_pitch;
   logic [KEY_W-1:0]   cand_key;
   logic               cand_ok;
   logic [7:0]         pat_pitch;
   logic               room;
   logic [RNG_W-1:0]   rnd_next;

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == ST_IDLE);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign falling     = (dir_ff == DIR_DOWN) || (dir_ff == DIR_DOWN_UP);
   assign note_on_evt = (req_command == CMD_NOTE_ON) && (req_velocity != '0);
   assign span_eff    = (span_ff == 3'd0) ? 3'd1 : span_ff;
   assign scan_pitch  = falling ? ~scan_ff[PITCH_W-1:0] : scan_ff[PITCH_W-1:0];
   assign cand_key    = {arr_rd_ff, pd_pitch_ff};
   assign cand_ok     = pd_valid_ff && held_ff[pd_pitch_ff]
                        && (first_ff || (cand_key > prev_key_ff))
                        && (!found_ff || (cand_key < best_key_ff));
   assign pat_pitch   = {1'b0, list_rd_ff[ENTRY_W-1:VEL_W]} + oct_off_ff;
   assign room        = (len_ff < LEN_W'(MAX_PATTERN));
   assign rnd_next    = xorshift32(rnd_ff);

   // remainder unit for random picks
   arp_rem_unit #(
      .LEN_W (LEN_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .req       (rem_req),
      .divisor   (len_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff      <= RST_DIRECTION;
         span_ff     <= RST_OCTAVE_SPAN;
         period_ff   <= RST_STEP_PERIOD;
         gate_len_ff <= RST_GATE_LENGTH;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIRECTION:   dir_ff      <= csr_wdata[2:0];
            CSR_OCTAVE_SPAN: span_ff     <= csr_wdata[2:0];
            CSR_STEP_PERIOD: period_ff   <= csr_wdata[TIMER_W-1:0];
            CSR_GATE_LENGTH: gate_len_ff <= csr_wdata[TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer next state and datapath
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      held_cnt_in  = held_cnt_ff;
      order_in     = order_ff;
      last_chan_in = last_chan_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      snd_valid_in = snd_valid_ff;
      snd_note_in  = snd_note_ff;
      samples_in   = samples_ff;
      gate_in      = gate_ff;
      rnd_in       = rnd_ff;
      is_on_in     = is_on_ff;
      scan_in      = scan_ff;
      n_in         = n_ff;
      li_in        = li_ff;
      oct_j_in     = oct_j_ff;
      oct_off_in   = oct_off_ff;
      mir_in       = mir_ff;
      best_in      = best_ff;
      best_key_in  = best_key_ff;
      found_in     = found_ff;
      prev_key_in  = prev_key_ff;
      first_in     = first_ff;
      pd_valid_in  = 1'b0;
      pd_pitch_in  = scan_ff[PITCH_W-1:0];
      idx_in       = idx_ff;
      off_note_in  = off_note_ff;
      off_last_in  = off_last_ff;
      then_on_in   = then_on_ff;
      on_note_in   = on_note_ff;
      on_vel_in    = on_vel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_note_in  = rsp_note_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_last_in  = rsp_last_ff;
      vel_addr     = req_note;
      arr_addr     = scan_ff[PITCH_W-1:0];
      list_addr    = li_ff[PITCH_W-1:0];
      pat_addr     = mir_ff[POS_W-1:0];
      list_we      = 1'b0;
      list_waddr   = n_ff[PITCH_W-1:0];
      list_wdata   = {best_ff, vel_rd_ff};
      pat_we       = 1'b0;
      pat_waddr    = len_ff[POS_W-1:0];
      pat_wdata    = {pat_pitch[PITCH_W-1:0], list_rd_ff[VEL_W-1:0]};
      rem_req      = '{start: 1'b0, dividend: rnd_next};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_NOTE_ON || req_command == CMD_NOTE_OFF) begin
                  if (note_on_evt) begin
                     held_in[req_note] = 1'b1;
                     held_cnt_in  = held_cnt_ff + {7'd0, !held_ff[req_note]};
                     order_in     = order_ff + 16'd1;
                     last_chan_in = req_channel;
                     is_on_in     = 1'b1;
                  end else begin
                     held_in[req_note] = 1'b0;
                     held_cnt_in = held_cnt_ff - {7'd0, held_ff[req_note]};
                     is_on_in    = 1'b0;
                  end
                  // start the rebuild
                  n_in     = '0;
                  scan_in  = '0;
                  first_in = 1'b1;
                  found_in = 1'b0;
                  state_in = (dir_ff == DIR_AS_PLAYED) ? ST_SORT_PASS : ST_SCAN;
               end else if (req_command == CMD_TICK && len_ff != '0) begin
                  state_in = ST_TICK;
               end
            end
         end

         // walk pitches in scan order, listing the held ones
         ST_SCAN: begin
            vel_addr = scan_pitch;
            if (scan_ff[7]) begin
               li_in      = '0;
               oct_j_in   = '0;
               len_in     = '0;
               oct_off_in = falling ? 8'(({5'd0, span_eff} - 8'd1) * 8'(OCT_STEP)) : 8'd0;
               state_in   = (n_ff == '0) ? ST_FINISH : ST_PAT_RD;
            end else begin
               scan_in = scan_ff + 8'd1;
               if (held_ff[scan_pitch]) begin
                  best_in  = scan_pitch;
                  state_in = ST_SCAN_WR;
               end
            end
         end

         ST_SCAN_WR: begin
            list_we  = 1'b1;
            n_in     = n_ff + 8'd1;
            state_in = ST_SCAN;
         end

         // as played: each pass picks the smallest key above the last one
         ST_SORT_PASS: begin
            pd_valid_in = !scan_ff[7];
            if (cand_ok) begin
               found_in    = 1'b1;
               best_in     = pd_pitch_ff;
               best_key_in = cand_key;
            end
            if (scan_ff[7]) begin
               if (cand_ok || found_ff) begin
                  state_in = ST_SORT_VEL;
               end else begin
                  li_in      = '0;
                  oct_j_in   = '0;
                  len_in     = '0;
                  oct_off_in = 8'd0;
                  state_in   = (n_ff == '0) ? ST_FINISH : ST_PAT_RD;
               end
            end else begin
               scan_in = scan_ff + 8'd1;
            end
         end

         ST_SORT_VEL: begin
            vel_addr = best_ff;
            state_in = ST_SORT_WR;
         end

         ST_SORT_WR: begin
            list_we     = 1'b1;
            n_in        = n_ff + 8'd1;
            prev_key_in = best_key_ff;
            first_in    = 1'b0;
            found_in    = 1'b0;
            scan_in     = '0;
            state_in    = ST_SORT_PASS;
         end

         // octave copies of the list into the pattern
         ST_PAT_RD: begin
            state_in = ST_PAT_WR;
         end

         ST_PAT_WR: begin
            if (pat_pitch <= 8'(MAX_PITCH) && room) begin
               pat_we = 1'b1;
               len_in = len_ff + 1'b1;
            end
            state_in = ST_PAT_RD;
            if (8'(li_ff + 8'd1) == n_ff) begin
               li_in    = '0;
               oct_j_in = oct_j_ff + 3'd1;
               oct_off_in = falling ? oct_off_ff - 8'(OCT_STEP) : oct_off_ff + 8'(OCT_STEP);
               if (oct_j_ff + 3'd1 == span_eff) begin
                  if ((dir_ff == DIR_UP_DOWN || dir_ff == DIR_DOWN_UP)
                      && len_in > LEN_W'(2)) begin
                     mir_in   = len_in - LEN_W'(2);
                     state_in = ST_MIR_RD;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end else begin
               li_in = li_ff + 8'd1;
            end
         end

         // mirrored run without its endpoints
         ST_MIR_RD: begin
            state_in = ST_MIR_WR;
         end

         ST_MIR_WR: begin
            pat_wdata = pat_rd_ff;
            if (room) begin
               pat_we = 1'b1;
               len_in = len_ff + 1'b1;
            end
            if (mir_ff == LEN_W'(1)) begin
               state_in = ST_FINISH;
            end else begin
               mir_in   = mir_ff - 1'b1;
               state_in = ST_MIR_RD;
            end
         end

         ST_FINISH: begin
            state_in = ST_IDLE;
            if (n_ff != '0 && LEN_W'(pos_ff) >= len_ff) begin
               pos_in = '0;
            end
            if (is_on_ff) begin
               if (held_cnt_ff == 8'd1) begin
                  samples_in = '0;
                  pos_in     = '0;
               end
            end else if (len_ff == '0 && snd_valid_ff) begin
               snd_valid_in = 1'b0;
               off_note_in  = snd_note_ff;
               off_last_in  = 1'b1;
               then_on_in   = 1'b0;
               state_in     = ST_EMIT_OFF;
            end
         end

         // one sample of timing
         ST_TICK: begin
            off_note_in = snd_note_ff;
            if (samples_ff != '0) begin
               samples_in = samples_ff - 1'b1;
               if (gate_ff != '0) begin
                  gate_in = gate_ff - 1'b1;
               end
               state_in = ST_IDLE;
               if (snd_valid_ff && gate_ff == '0) begin
                  snd_valid_in = 1'b0;
                  off_last_in  = 1'b1;
                  then_on_in   = 1'b0;
                  state_in     = ST_EMIT_OFF;
               end
            end else if (dir_ff == DIR_RANDOM) begin
               rnd_in        = rnd_next;
               rem_req.start = 1'b1;
               state_in      = ST_TK_REM;
            end else begin
               idx_in   = pos_ff;
               state_in = ST_TK_RD;
            end
         end

         ST_TK_REM: begin
            if (rem_done) begin
               idx_in   = rem_value[POS_W-1:0];
               state_in = ST_TK_RD;
            end
         end

         ST_TK_RD: begin
            pat_addr = idx_ff;
            state_in = ST_TK_DATA;
         end

         ST_TK_DATA: begin
            on_note_in   = pat_rd_ff[ENTRY_W-1:VEL_W];
            on_vel_in    = pat_rd_ff[VEL_W-1:0];
            snd_valid_in = 1'b1;
            snd_note_in  = pat_rd_ff[ENTRY_W-1:VEL_W];
            gate_in      = (gate_len_ff == '0) ? '0 : gate_len_ff - 1'b1;
            samples_in   = (period_ff == '0) ? '0 : period_ff - 1'b1;
            pos_in       = (LEN_W'(idx_ff) + 1'b1 == len_ff) ? '0 : idx_ff + 1'b1;
            off_last_in  = 1'b0;
            then_on_in   = 1'b1;
            state_in     = snd_valid_ff ? ST_EMIT_OFF : ST_EMIT_ON;
         end

         ST_EMIT_OFF: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = EVT_NOTE_OFF;
               rsp_chan_in  = last_chan_ff;
               rsp_note_in  = off_note_ff;
               rsp_vel_in   = '0;
               rsp_last_in  = off_last_ff;
               state_in     = then_on_ff ? ST_EMIT_ON : ST_IDLE;
            end
         end

         ST_EMIT_ON: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = EVT_NOTE_ON;
               rsp_chan_in  = last_chan_ff;
               rsp_note_in  = on_note_ff;
               rsp_vel_in   = on_vel_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // a seed write reloads the generator
      if (csr_we && csr_index == CSR_RNG_SEED) begin
         rnd_in = csr_wdata;
      end
   end

   // state register and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         held_cnt_ff  <= '0;
         order_ff     <= '0;
         last_chan_ff <= '0;
         len_ff       <= '0;
         pos_ff       <= '0;
         snd_valid_ff <= 1'b0;
         snd_note_ff  <= '0;
         samples_ff   <= '0;
         gate_ff      <= '0;
         rnd_ff       <= RST_RNG_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         held_cnt_ff  <= held_cnt_in;
         order_ff     <= order_in;
         last_chan_ff <= last_chan_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         snd_valid_ff <= snd_valid_in;
         snd_note_ff  <= snd_note_in;
         samples_ff   <= samples_in;
         gate_ff      <= gate_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      is_on_ff    <= is_on_in;
      scan_ff     <= scan_in;
      n_ff        <= n_in;
      li_ff       <= li_in;
      oct_j_ff    <= oct_j_in;
      oct_off_ff  <= oct_off_in;
      mir_ff      <= mir_in;
      best_ff     <= best_in;
      best_key_ff <= best_key_in;
      found_ff    <= found_in;
      prev_key_ff <= prev_key_in;
      first_ff    <= first_in;
      pd_valid_ff <= pd_valid_in;
      pd_pitch_ff <= pd_pitch_in;
      idx_ff      <= idx_in;
      off_note_ff <= off_note_in;
      off_last_ff <= off_last_in;
      then_on_ff  <= then_on_in;
      on_note_ff  <= on_note_in;
      on_vel_ff   <= on_vel_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_note_ff <= rsp_note_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_last_ff <= rsp_last_in;
   end

   // held note memories, used only where the held bit is set
   always_ff @(posedge clock) begin
      if (accept && note_on_evt) begin
         vel_mem[req_note] <= req_velocity;
         arr_mem[req_note] <= order_ff + 16'd1;
      end
      vel_rd_ff <= vel_mem[vel_addr];
      arr_rd_ff <= arr_mem[arr_addr];
   end

   // sorted pitch list
   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_waddr] <= list_wdata;
      end
      list_rd_ff <= list_mem[list_addr];
   end

   // step pattern
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pat_waddr] <= pat_wdata;
      end
      pat_rd_ff <= pat_mem[pat_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_out_channel  = rsp_chan_ff;
   assign rsp_out_note     = rsp_note_ff;
   assign rsp_out_velocity = rsp_vel_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== design/arp_rem_unit.sv =====
// bit-serial remainder unit: 32-bit dividend modulo pattern length
`timescale 1ns / 1ps

module arp_rem_unit
   import arp_pkg::*;
#(
   parameter int LEN_W = 7
) (
   input  logic            clock,
   input  logic            reset,
   input  arp_rem_req_type req,
   input  logic [LEN_W-1:0] divisor,
   output logic            done,
   output logic [LEN_W-1:0] remainder
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [RNG_W-1:0] dvd_ff, dvd_in;
   logic [LEN_W-1:0] div_ff, div_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [LEN_W:0]   shifted;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, dvd_ff[RNG_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = req.dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = LEN_W'(shifted - {1'b0, div_ff});
         end else begin
            rem_in = LEN_W'(shifted);
         end
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/arp_checker.sv =====
// port-level checks of the arpeggiator, bound to the top level
`timescale 1ns / 1ps

module arp_checker
   import arp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_event_kind,
   input logic [6:0]  rsp_out_note,
   input logic [15:0] rsp_out_velocity
);

   // a held result stays until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // note off results carry zero velocity
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EVT_NOTE_OFF |-> rsp_out_velocity == '0)
      else $error("note off with velocity");

   // a waiting result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_event_kind) && $stable(rsp_out_note)
                                  && $stable(rsp_out_velocity))
      else $error("result payload changed while waiting");

endmodule

bind note_arpeggiator_unit arp_checker u_arp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_out_note     (rsp_out_note),
   .rsp_out_velocity (rsp_out_velocity)
);

// ===== test/arp_checker.sv =====
// checker: predicts arpeggiator events from observed transfers and compares them
`timescale 1ns / 1ps

module arp_scoreboard
   import arp_pkg::*;
#(
   parameter int PATTERN_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_note,
   input  logic [15:0] req_velocity,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_event_kind,
   input  logic [3:0]  rsp_out_channel,
   input  logic [6:0]  rsp_out_note,
   input  logic [15:0] rsp_out_velocity,
   input  logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          error_count,
   output int          events_pending
);

   typedef struct packed {
      logic        kind;
      logic [3:0]  chan;
      logic [6:0]  note;
      logic [15:0] vel;
      logic        last;
   } arp_event_type;

   arp_event_type expected_events[$];

   // register copies
   logic [2:0]  cfg_dir;
   logic [2:0]  cfg_octaves;
   logic [19:0] cfg_period;
   logic [19:0] cfg_gate;

   // model state
   logic [15:0] held_vel[NUM_PITCH];
   logic [15:0] arrival[NUM_PITCH];
   logic [15:0] order_ctr;
   logic [6:0]  pat_pitch[PATTERN_DEPTH];
   logic [15:0] pat_vel[PATTERN_DEPTH];
   int          pat_len;
   int          step_pos;
   logic        sounding;
   logic [6:0]  sound_note;
   logic [3:0]  last_chan;
   logic [19:0] to_step;
   logic [19:0] gate_left;
   logic [31:0] rng;

   assign events_pending = expected_events.size();

   function automatic void add_step(int pitch, logic [15:0] vel);
      if (pat_len < PATTERN_DEPTH) begin
         pat_pitch[pat_len] = pitch[6:0];
         pat_vel[pat_len] = vel;
         pat_len++;
      end
   endfunction

   // rebuild the step pattern from the held pitches
   function automatic void rebuild_pattern();
      int list[NUM_PITCH];
      int n, span, oct, p, i, j, key, base;
      logic falling;
      falling = (cfg_dir == DIR_DOWN) || (cfg_dir == DIR_DOWN_UP);
      n = 0;
      for (i = 0; i < NUM_PITCH; i++) begin
         p = falling ? (NUM_PITCH - 1 - i) : i;
         if (held_vel[p] != 0) begin
            list[n] = p;
            n++;
         end
      end
      if (n == 0) begin
         pat_len = 0;
         return;
      end
      // stable insertion sort on arrival stamp
      if (cfg_dir == DIR_AS_PLAYED) begin
         for (i = 1; i < n; i++) begin
            key = list[i];
            j = i;
            while (j > 0 && arrival[list[j-1]] > arrival[key]) begin
               list[j] = list[j-1];
               j--;
            end
            list[j] = key;
         end
      end
      span = (cfg_octaves == 0) ? 1 : int'(cfg_octaves);
      pat_len = 0;
      for (j = 0; j < span; j++) begin
         oct = falling ? (span - 1 - j) : j;
         for (i = 0; i < n; i++) begin
            p = list[i] + oct * OCT_STEP;
            if (p <= MAX_PITCH) add_step(p, held_vel[list[i]]);
         end
      end
      // mirrored run without endpoints
      if (cfg_dir == DIR_UP_DOWN || cfg_dir == DIR_DOWN_UP) begin
         base = pat_len;
         if (base > 2)
            for (i = base - 2; i >= 1; i--) add_step(pat_pitch[i], pat_vel[i]);
      end
      if (step_pos >= pat_len) step_pos = 0;
   endfunction

   function automatic void push_event(logic kind, logic [6:0] note, logic [15:0] vel);
      arp_event_type e;
      e.kind = kind;
      e.chan = last_chan;
      e.note = note;
      e.vel  = vel;
      e.last = 1'b0;
      expected_events.push_back(e);
   endfunction

   // next pseudo-random value
   function automatic logic [31:0] advance_rng();
      logic [31:0] r;
      r = rng;
      r = r ^ (r << 13);
      r = r ^ (r >> 17);
      r = r ^ (r << 5);
      rng = r;
      return r;
   endfunction

   // work out the events caused by one accepted item
   function automatic void predict_arp_events(logic [1:0] cmd, logic [3:0] chan,
                                              logic [6:0] note, logic [15:0] vel);
      int prior_size, count, i, idx;
      logic step_now;
      prior_size = expected_events.size();
      if (cmd == CMD_NOTE_ON && vel != 0) begin
         held_vel[note] = vel;
         last_chan = chan;
         order_ctr = order_ctr + 16'd1;
         arrival[note] = order_ctr;
         rebuild_pattern();
         count = 0;
         for (i = 0; i < NUM_PITCH; i++) if (held_vel[i] != 0) count++;
         if (count == 1) begin
            to_step = 0;
            step_pos = 0;
         end
      end else if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
         held_vel[note] = 0;
         arrival[note] = 0;
         rebuild_pattern();
         if (pat_len == 0 && sounding) begin
            push_event(EVT_NOTE_OFF, sound_note, 16'd0);
            sounding = 1'b0;
         end
      end else if (cmd == CMD_TICK && pat_len > 0) begin
         step_now = (to_step == 0);
         if (sounding && gate_left == 0 && !step_now) begin
            push_event(EVT_NOTE_OFF, sound_note, 16'd0);
            sounding = 1'b0;
         end
         if (step_now) begin
            idx = step_pos % pat_len;
            if (sounding) push_event(EVT_NOTE_OFF, sound_note, 16'd0);
            if (cfg_dir == DIR_RANDOM) idx = int'(advance_rng() % pat_len);
            push_event(EVT_NOTE_ON, pat_pitch[idx], pat_vel[idx]);
            sounding = 1'b1;
            sound_note = pat_pitch[idx];
            gate_left = (cfg_gate == 0) ? 20'd1 : cfg_gate;
            to_step = (cfg_period == 0) ? 20'd1 : cfg_period;
            step_pos = (idx + 1) % pat_len;
         end
         if (to_step > 0) to_step--;
         if (gate_left > 0) gate_left--;
      end
      if (expected_events.size() > prior_size)
         expected_events[expected_events.size() - 1].last = 1'b1;
   endfunction

   // watch the ports
   always @(posedge clock) begin
      arp_event_type e;
      if (reset) begin
         cfg_dir = RST_DIRECTION;
         cfg_octaves = RST_OCTAVE_SPAN;
         cfg_period = RST_STEP_PERIOD;
         cfg_gate = RST_GATE_LENGTH;
         rng = RST_RNG_SEED;
         for (int i = 0; i < NUM_PITCH; i++) begin
            held_vel[i] = 0;
            arrival[i] = 0;
         end
         order_ctr = 0;
         pat_len = 0;
         step_pos = 0;
         sounding = 1'b0;
         sound_note = 0;
         last_chan = 0;
         to_step = 0;
         gate_left = 0;
         expected_events.delete();
         error_count = 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_DIRECTION:   cfg_dir = csr_wdata[2:0];
               CSR_OCTAVE_SPAN: cfg_octaves = csr_wdata[2:0];
               CSR_STEP_PERIOD: cfg_period = csr_wdata[19:0];
               CSR_GATE_LENGTH: cfg_gate = csr_wdata[19:0];
               CSR_RNG_SEED:    rng = csr_wdata;
               default: ;
            endcase
         end
         // input transfer
         if (req_valid && req_ready)
            predict_arp_events(req_command, req_channel, req_note, req_velocity);
         // result transfer
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected event kind=%0d ch=%0d note=%0d vel=%0d last=%0d",
                           $realtime, rsp_event_kind, rsp_out_channel, rsp_out_note,
                           rsp_out_velocity, rsp_last);
            end else begin
               e = expected_events.pop_front();
               if (e.kind !== rsp_event_kind || e.chan !== rsp_out_channel ||
                   e.note !== rsp_out_note || e.vel !== rsp_out_velocity ||
                   e.last !== rsp_last) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $write("%0t: mismatch exp kind=%0d ch=%0d note=%0d vel=%0d last=%0d",
                            $realtime, e.kind, e.chan, e.note, e.vel, e.last);
                     $display(", got kind=%0d ch=%0d note=%0d vel=%0d last=%0d",
                              rsp_event_kind, rsp_out_channel, rsp_out_note,
                              rsp_out_velocity, rsp_last);
                  end
               end
            end
         end
      end
   end

endmodule

// ===== test/tb_top.sv =====
// testbench top: stimulus, handshake pacing and verdict for the arpeggiator
`timescale 1ns / 1ps

module tb_top;
   import arp_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 20000;
   localparam int PATTERN_DEPTH = 64;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [3:0]  req_channel;
   logic [6:0]  req_note;
   logic [15:0] req_velocity;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_event_kind;
   logic [3:0]  rsp_out_channel;
   logic [6:0]  rsp_out_note;
   logic [15:0] rsp_out_velocity;
   logic        rsp_last;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   int          error_count;
   int          events_pending;

   int   tx_idle_pct;
   int   rx_stall_pct;
   int   phase_num;
   int   hold_cnt;
   logic hold_done;
   logic held[NUM_PITCH];
   int   held_total;

   note_arpeggiator_unit #(
      .MAX_PATTERN (PATTERN_DEPTH)
   ) uut (.*);

   arp_scoreboard #(
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) u_scoreboard (.*);

   always #10 clock = ~clock;

   // receiver pacing, with one long hold-off early in the second phase
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cnt <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && phase_num == 1) begin
         hold_cnt <= 600;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
         rsp_ready <= (hold_cnt == 0) && ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // one input transfer, with random idle cycles ahead of it
   task automatic send_item(logic [1:0] cmd, logic [3:0] chan, logic [6:0] note,
                            logic [15:0] vel);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_channel <= chan;
      req_note <= note;
      req_velocity <= vel;
      do @(posedge clock); while (!req_ready);
      if (cmd == CMD_NOTE_ON && vel != 0) begin
         if (!held[note]) held_total++;
         held[note] = 1'b1;
      end else if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
         if (held[note]) held_total--;
         held[note] = 1'b0;
      end
   endtask

   // wait on the clock until every predicted event has arrived
   task automatic drain_events();
      do @(posedge clock); while (events_pending != 0);
   endtask

   // quiet the block, then write every register
   task automatic program_regs(logic [2:0] dir, logic [2:0] octaves, logic [19:0] period,
                               logic [19:0] gate, logic [31:0] seed);
      req_valid <= 1'b0;
      drain_events();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_DIRECTION;   csr_wdata <= 32'(dir);     @(posedge clock);
      csr_index <= CSR_OCTAVE_SPAN; csr_wdata <= 32'(octaves); @(posedge clock);
      csr_index <= CSR_STEP_PERIOD; csr_wdata <= 32'(period);  @(posedge clock);
      csr_index <= CSR_GATE_LENGTH; csr_wdata <= 32'(gate);    @(posedge clock);
      csr_index <= CSR_RNG_SEED;    csr_wdata <= seed;         @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // random item mix: mostly ticks and note events on a small held set
   task automatic send_random_items(int count);
      int sent, pick, k, start;
      logic [6:0] nt;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            send_item(CMD_UNUSED, 4'($urandom), 7'($urandom), 16'($urandom));
            continue;
         end
         if (pick < 48) begin
            send_item(CMD_TICK, 4'($urandom), 7'($urandom), 16'($urandom));
         end else if ((pick < 75 && held_total < 6) || held_total == 0) begin
            send_item(CMD_NOTE_ON, 4'($urandom), 7'($urandom),
                      ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom));
         end else if (pick < 95 || held_total >= 6) begin
            // release one held pitch
            start = $urandom_range(NUM_PITCH - 1);
            nt = 7'(start);
            for (k = 0; k < NUM_PITCH; k++)
               if (held[(start + k) % NUM_PITCH]) nt = 7'((start + k) % NUM_PITCH);
            send_item(CMD_NOTE_OFF, 4'($urandom), nt, 16'($urandom));
         end else begin
            send_item(CMD_NOTE_OFF, 4'($urandom), 7'($urandom), 16'($urandom));
         end
         sent++;
      end
   endtask

   // run limit
   initial begin
      #60ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_NOTE_ON;
      req_channel <= 4'd0;
      req_note <= 7'd0;
      req_velocity <= 16'd0;
      csr_we <= 1'b0;
      csr_index <= CSR_DIRECTION;
      csr_wdata <= 32'd0;
      tx_idle_pct = 8;
      rx_stall_pct = 76;
      phase_num = 0;
      held_total = 0;
      for (int i = 0; i < NUM_PITCH; i++) held[i] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and the corner behaviors
      program_regs(DIR_UP, 3'd1, 20'd3, 20'd2, 32'd1);
      send_item(CMD_NOTE_ON, 4'd15, 7'd0, 16'hFFFF);      // first held note
      send_item(CMD_NOTE_ON, 4'd0, 7'd127, 16'd1);
      repeat (4) send_item(CMD_TICK, 4'd0, 7'd0, 16'd0);
      send_item(CMD_NOTE_ON, 4'd5, 7'd127, 16'd0);        // zero velocity acts as off
      send_item(CMD_TICK, 4'd0, 7'd0, 16'd0);
      send_item(CMD_NOTE_OFF, 4'd0, 7'd0, 16'd0);         // last note released
      send_item(CMD_TICK, 4'd0, 7'd0, 16'd0);             // empty pattern
      send_item(CMD_UNUSED, 4'd15, 7'd127, 16'hFFFF);     // ignored command
      send_item(CMD_NOTE_ON, 4'd9, 7'd60, 16'h8000);
      send_item(CMD_NOTE_ON, 4'd3, 7'd64, 16'h00FF);
      repeat (6) send_item(CMD_TICK, 4'd0, 7'd0, 16'd0);  // steps with a gate that ends before the next step
      send_item(CMD_NOTE_OFF, 4'd0, 7'd61, 16'd0);        // release of a pitch not held
      send_item(CMD_NOTE_OFF, 4'd0, 7'd64, 16'd0);
      send_item(CMD_NOTE_OFF, 4'd0, 7'd60, 16'd0);
      // sender pauses until every event has arrived
      req_valid <= 1'b0;
      drain_events();
      send_random_items(64);

      for (int ph = 1; ph < 9; ph++) begin
         tx_idle_pct = (ph < 3) ? 8 : (ph < 6) ? 76 : 0;
         rx_stall_pct = (ph < 3) ? 76 : (ph < 6) ? 8 : 0;
         case (ph)
            1: program_regs(DIR_DOWN, 3'd4, 20'd1, 20'd1, 32'hFFFF_FFFF);
            2: program_regs(DIR_UP_DOWN, 3'd2, 20'd4, 20'd9, 32'd7);
            3: program_regs(DIR_DOWN_UP, 3'd3, 20'd5, 20'd5, 32'd1);
            4: program_regs(DIR_AS_PLAYED, 3'd1, 20'd2, 20'd1, 32'd1);
            5: program_regs(DIR_RANDOM, 3'd2, 20'd3, 20'd1, 32'hFFFF_FFFF);
            6: program_regs(3'd6, 3'd0, 20'd0, 20'd0, 32'd0);
            7: program_regs(3'd7, 3'd7, 20'hFFFFF, 20'hFFFFF, $urandom);
            default: program_regs(DIR_RANDOM, 3'd4, 20'd3, 20'd2, $urandom | 32'd1);
         endcase
         phase_num = ph;
         send_random_items(64);
      end

      req_valid <= 1'b0;
      drain_events();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && events_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
design/arp_pkg.sv
design/arp_rem_unit.sv
design/note_arpeggiator_unit.sv
design/arp_checker.sv
test/arp_checker.sv
test/tb_top.sv
